// ===== design/ssbs_pkg.sv =====
// Shared constants, types and segment tables for the bargraph serializer.
package ssbs_pkg;

	localparam int WORD_BITS = 32;
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int REM_W     = 10;	// number mod 1000

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_BITS - 1);

	// payload held in the second stage
	typedef struct packed {
		logic                 cmd;
		logic [REM_W-1:0]     rem;
		logic [3:0]           bar;
		logic [WORD_BITS-1:0] raw;
	} item_s2_t;

	typedef enum logic {
		CMD_NUMBER = 1'b0,
		CMD_RAW    = 1'b1
	} cmd_t;

	// display 1 and display 3 share one pattern set, in different halves
	function automatic logic [15:0] seg_outer(input logic [3:0] d);
		logic [15:0] p;
		case (d)
			4'd0:    p = 16'h7007;
			4'd1:    p = 16'h4001;
			4'd2:    p = 16'h300B;
			4'd3:    p = 16'h600B;
			4'd4:    p = 16'h400D;
			4'd5:    p = 16'h600E;
			4'd6:    p = 16'h700E;
			4'd7:    p = 16'h4003;
			4'd8:    p = 16'h700F;
			4'd9:    p = 16'h600F;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	function automatic logic [15:0] seg_tens(input logic [3:0] d);
		logic [15:0] p;
		case (d)
			4'd0:    p = 16'h0770;
			4'd1:    p = 16'h0410;
			4'd2:    p = 16'h03B0;
			4'd3:    p = 16'h06B0;
			4'd4:    p = 16'h04D0;
			4'd5:    p = 16'h06E0;
			4'd6:    p = 16'h07E0;
			4'd7:    p = 16'h0430;
			4'd8:    p = 16'h07F0;
			4'd9:    p = 16'h06F0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// upper half only; levels above eight are dark
	function automatic logic [15:0] bar_pattern(input logic [3:0] lvl);
		logic [15:0] p;
		case (lvl)
			4'd0:    p = 16'h0000;
			4'd1:    p = 16'h0100;
			4'd2:    p = 16'h0300;
			4'd3:    p = 16'h0700;
			4'd4:    p = 16'h0F00;
			4'd5:    p = 16'h0F80;
			4'd6:    p = 16'h0FC0;
			4'd7:    p = 16'h0FE0;
			4'd8:    p = 16'h0FF0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

endpackage

// ===== design/ssbs_word_build.sv =====
// Splits the three-digit remainder into digits for the word; raw words pass.
module ssbs_word_build (
	input  ssbs_pkg::item_s2_t                 item,
	output logic [ssbs_pkg::WORD_BITS-1:0]     word
);

	logic [15:0] hund_prod;
	logic [3:0]  hund;
	logic [10:0] hund_x100;
	logic [6:0]  rem2;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [7:0]  tens_x10;
	logic [3:0]  units;
	logic [15:0] upper;
	logic [15:0] lower;

	// r/100 as (r*41)>>12, exact for r below 1000
	assign hund_prod = 16'(item.rem) * 16'd41;
	assign hund      = hund_prod[15:12];
	assign hund_x100 = 11'(hund) * 11'd100;
	assign rem2      = 7'(11'(item.rem) - hund_x100);

	// r/10 as (r*205)>>11, exact for r below 100
	assign tens_prod = 15'(rem2) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign tens_x10  = 8'(tens) * 8'd10;
	assign units     = 4'(8'(rem2) - tens_x10);

	assign upper = ssbs_pkg::seg_outer(hund) | ssbs_pkg::bar_pattern(item.bar);
	assign lower = ssbs_pkg::seg_tens(tens) | ssbs_pkg::seg_outer(units);

	always_comb begin
		if (item.cmd == ssbs_pkg::CMD_RAW) begin
			word = item.raw;
		end else begin
			word = {upper, lower};
		end
	end

endmodule

// ===== design/seven_segment_bargraph_serializer_unit.sv =====
// Top level of the seven-segment and bargraph serializer.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  item    | item_valid, item_ready | cmd, number_value, bar_level, raw_word
//  bit     | bit_valid, bit_ready   | serial_bit, bit_position, latch_strobe
//
// Every item yields 32 bit transfers, one per cycle while bit_ready is high, so
// the sustained item rate is set by the output shift register.
// The item enters the input register on the transfer edge, then passes the
// mod-1000 register and is loaded into the shift register, which offers bit 0.
// The next item is taken and prepared while the current word is still shifting.
// arst_n clears all valid flags and the bit counter; no clearing pass is needed.
module seven_segment_bargraph_serializer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        cmd,
	input  logic [15:0] number_value,
	input  logic [3:0]  bar_level,
	input  logic [31:0] raw_word,
	output logic        bit_valid,
	input  logic        bit_ready,
	output logic        serial_bit,
	output logic [4:0]  bit_position,
	output logic        latch_strobe
);

	localparam int WB = ssbs_pkg::WORD_BITS;
	localparam int PW = ssbs_pkg::POS_W;
	localparam int RW = ssbs_pkg::REM_W;

	// stage 1: input register
	logic          v_s1;
	logic          cmd_s1;
	logic [15:0]   num_s1;
	logic [3:0]    bar_s1;
	logic [WB-1:0] raw_s1;

	// stage 2: residue mod 1000
	logic               v_s2;
	ssbs_pkg::item_s2_t item_s2;

	// stage 3: output shift register
	logic          v_s3;
	logic [WB-1:0] sh_s3;
	logic [PW-1:0] cnt_s3;

	logic          bit_xfer;
	logic          last_bit;
	logic          load_s3;
	logic          adv_s2;
	logic [32:0]   div_prod;
	logic [6:0]    kilo;
	logic [16:0]   kilo_x1000;
	logic [RW-1:0] rem_s1;
	logic [WB-1:0] word;

	assign bit_xfer = bit_valid && bit_ready;
	assign last_bit = cnt_s3 == ssbs_pkg::LAST_POS;
	assign load_s3  = v_s2 && (!v_s3 || (bit_xfer && last_bit));
	assign adv_s2   = v_s1 && (!v_s2 || load_s3);
	assign item_ready = !v_s1 || adv_s2;

	// n/1000 as (n*67109)>>26, exact over the 16-bit range
	assign div_prod   = 33'(num_s1) * 33'd67109;
	assign kilo       = div_prod[32:26];
	assign kilo_x1000 = 17'(kilo) * 17'd1000;
	assign rem_s1     = RW'(17'(num_s1) - kilo_x1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1 <= cmd;
			num_s1 <= number_value;
			bar_s1 <= bar_level;
			raw_s1 <= raw_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || load_s3) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			item_s2.cmd <= cmd_s1;
			item_s2.rem <= rem_s1;
			item_s2.bar <= bar_s1;
			item_s2.raw <= raw_s1;
		end
	end

	ssbs_word_build u_word (
		.item (item_s2),
		.word (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			cnt_s3 <= '0;
		end else if (load_s3) begin
			v_s3   <= 1'b1;
			cnt_s3 <= '0;
		end else if (bit_xfer) begin
			v_s3   <= !last_bit;
			cnt_s3 <= cnt_s3 + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			sh_s3 <= word;
		end else if (bit_xfer) begin
			sh_s3 <= sh_s3 >> 1;
		end
	end

	assign bit_valid    = v_s3;
	assign serial_bit   = sh_s3[0];
	assign bit_position = cnt_s3;
	assign latch_strobe = last_bit;

endmodule

// ===== design/ssbs_checker.sv =====
// Port-level checks for the serializer, bound to the top level.
module ssbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        cmd,
	input logic [15:0] number_value,
	input logic [3:0]  bar_level,
	input logic [31:0] raw_word,
	input logic        bit_valid,
	input logic        bit_ready,
	input logic        serial_bit,
	input logic [4:0]  bit_position,
	input logic        latch_strobe
);

	// a word that starts after bit_valid was low begins at bit zero
	a_word_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bit_valid) |-> bit_position == 5'd0)
		else $error("word did not start at bit zero");

	// bits of a word follow one another without gaps
	a_bit_order: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid && bit_ready && !latch_strobe
			|=> bit_valid && bit_position == $past(bit_position) + 5'd1)
		else $error("bit sequence broken");

	// strobe marks exactly the last bit position
	a_strobe_pos: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid |-> latch_strobe == (bit_position == 5'd31))
		else $error("latch strobe on wrong bit");

	// stalled bit transfer holds its payload
	a_bit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid && !bit_ready
			|=> bit_valid && $stable(serial_bit) && $stable(bit_position))
		else $error("bit payload changed while stalled");

endmodule

bind seven_segment_bargraph_serializer_unit ssbs_checker u_ssbs_checker (.*);

// ===== bench/ssbs_bit_checker.sv =====
// Watches both channels of the bargraph serializer, predicts each bit and counts mismatches.
module ssbs_bit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic        cmd,
	input  logic [15:0] number_value,
	input  logic [3:0]  bar_level,
	input  logic [31:0] raw_word,
	input  logic        bit_valid,
	input  logic        bit_ready,
	input  logic        serial_bit,
	input  logic [4:0]  bit_position,
	input  logic        latch_strobe,
	output int          mismatch_count,
	output int          pending_bits
);

	typedef struct packed {
		logic       sbit;
		logic [4:0] pos;
		logic       strobe;
	} bit_slot_t;

	bit_slot_t   expected_bits[$];
	bit_slot_t   want;
	logic [31:0] next_word;

	// display 1 (upper half) and display 3 (lower half) use the same segment set
	function automatic logic [15:0] outer_segments(input int unsigned digit);
		case (digit)
			0:       return 16'h7007;
			1:       return 16'h4001;
			2:       return 16'h300B;
			3:       return 16'h600B;
			4:       return 16'h400D;
			5:       return 16'h600E;
			6:       return 16'h700E;
			7:       return 16'h4003;
			8:       return 16'h700F;
			default: return 16'h600F;
		endcase
	endfunction

	function automatic logic [15:0] tens_segments(input int unsigned digit);
		case (digit)
			0:       return 16'h0770;
			1:       return 16'h0410;
			2:       return 16'h03B0;
			3:       return 16'h06B0;
			4:       return 16'h04D0;
			5:       return 16'h06E0;
			6:       return 16'h07E0;
			7:       return 16'h0430;
			8:       return 16'h07F0;
			default: return 16'h06F0;
		endcase
	endfunction

	function automatic logic [15:0] bargraph_leds(input logic [3:0] lvl);
		case (lvl)
			4'd1:    return 16'h0100;
			4'd2:    return 16'h0300;
			4'd3:    return 16'h0700;
			4'd4:    return 16'h0F00;
			4'd5:    return 16'h0F80;
			4'd6:    return 16'h0FC0;
			4'd7:    return 16'h0FE0;
			4'd8:    return 16'h0FF0;
			default: return 16'h0000;	// level 0, and 9 and above are dark
		endcase
	endfunction

	function automatic logic [31:0] display_word(input logic c, input logic [15:0] num,
			input logic [3:0] lvl, input logic [31:0] raw);
		int unsigned rem;
		if (c == ssbs_pkg::CMD_RAW)
			return raw;
		rem = num % 1000;
		return {outer_segments(rem / 100) | bargraph_leds(lvl),
			tens_segments((rem / 10) % 10) | outer_segments(rem % 10)};
	endfunction

	task automatic note_mismatch(input string what, input bit_slot_t exp_slot,
			input bit_slot_t act_slot);
		if (mismatch_count < 10) begin
			$write("mismatch %s: expected bit=%0d pos=%0d strobe=%0d",
				what, exp_slot.sbit, exp_slot.pos, exp_slot.strobe);
			$display(", got bit=%0d pos=%0d strobe=%0d",
				act_slot.sbit, act_slot.pos, act_slot.strobe);
		end
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		pending_bits   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bits.delete();
		end else begin
			if (item_valid && item_ready) begin
				next_word = display_word(cmd, number_value, bar_level, raw_word);
				for (int k = 0; k < ssbs_pkg::WORD_BITS; k++)
					expected_bits.push_back('{next_word[k], 5'(k),
						k == ssbs_pkg::WORD_BITS - 1});
			end
			if (bit_valid && bit_ready) begin
				if (expected_bits.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected bit transfer: bit=%0d pos=%0d strobe=%0d",
							serial_bit, bit_position, latch_strobe);
					mismatch_count++;
				end else begin
					want = expected_bits.pop_front();
					if (serial_bit !== want.sbit)
						note_mismatch("serial_bit", want, {serial_bit, bit_position, latch_strobe});
					if (bit_position !== want.pos)
						note_mismatch("bit_position", want, {serial_bit, bit_position, latch_strobe});
					if (latch_strobe !== want.strobe)
						note_mismatch("latch_strobe", want, {serial_bit, bit_position, latch_strobe});
				end
			end
		end
		pending_bits = expected_bits.size();
	end

endmodule

// ===== bench/tb_seven_segment_bargraph_serializer_unit.sv =====
// Testbench top: clock, reset, item stimulus, output stalls and the final verdict.
module tb_seven_segment_bargraph_serializer_unit;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 150;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic        cmd;
	logic [15:0] number_value;
	logic [3:0]  bar_level;
	logic [31:0] raw_word;
	logic        bit_valid;
	logic        bit_ready;
	logic        serial_bit;
	logic [4:0]  bit_position;
	logic        latch_strobe;

	int mismatch_count;
	int pending_bits;
	int idle_cycles;
	int burst_left;

	logic [15:0] stall_mask;
	int          mask_idx;
	int          ready_mode;
	int          mode_cycles;

	seven_segment_bargraph_serializer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.number_value (number_value),
		.bar_level    (bar_level),
		.raw_word     (raw_word),
		.bit_valid    (bit_valid),
		.bit_ready    (bit_ready),
		.serial_bit   (serial_bit),
		.bit_position (bit_position),
		.latch_strobe (latch_strobe)
	);

	ssbs_bit_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.cmd            (cmd),
		.number_value   (number_value),
		.bar_level      (bar_level),
		.raw_word       (raw_word),
		.bit_valid      (bit_valid),
		.bit_ready      (bit_ready),
		.serial_bit     (serial_bit),
		.bit_position   (bit_position),
		.latch_strobe   (latch_strobe),
		.mismatch_count (mismatch_count),
		.pending_bits   (pending_bits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input ssbs_pkg::cmd_t c, input logic [15:0] num,
			input logic [3:0] lvl, input logic [31:0] raw);
		item_valid   = 1'b1;
		cmd          = c;
		number_value = num;
		bar_level    = lvl;
		raw_word     = raw;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// bursts of back-to-back items separated by idle gaps of random length
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				item_valid   = 1'b0;
				number_value = 16'($urandom);
				raw_word     = $urandom;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
	endtask

	// receiver stalls: phases of always-ready, a random mask, or a sparse mask
	always @(negedge clk) begin
		if (mode_cycles == 0) begin
			ready_mode  = $urandom_range(0, 2);
			mode_cycles = $urandom_range(20, 120);
			stall_mask  = 16'($urandom);
			if (ready_mode == 2)
				stall_mask = stall_mask & 16'($urandom) & 16'($urandom);
			stall_mask[$urandom_range(0, 15)] = 1'b1;
		end
		mode_cycles--;
		bit_ready = (ready_mode == 0) ? 1'b1 : stall_mask[mask_idx];
		mask_idx  = (mask_idx + 1) % 16;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (bit_valid && bit_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0]     nums[16];
		logic [31:0]     raws[5];
		ssbs_pkg::cmd_t  c;

		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		cmd          = ssbs_pkg::CMD_NUMBER;
		number_value = '0;
		bar_level    = '0;
		raw_word     = '0;
		bit_ready    = 1'b0;
		idle_cycles  = 0;
		burst_left   = 0;
		mask_idx     = 0;
		mode_cycles  = 0;
		ready_mode   = 0;
		stall_mask   = 16'hFFFF;

		// digit eight in every position, dropped high digits, field extremes
		nums = '{16'd0, 16'd999, 16'd1000, 16'd888, 16'd65535, 16'd8, 16'd80, 16'd800,
			16'd123, 16'd456, 16'd707, 16'd65000, 16'd1234, 16'd390, 16'd518, 16'd61};
		raws = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// number mode across every bargraph level, bright and dark
		for (int i = 0; i < 16; i++)
			send_item(ssbs_pkg::CMD_NUMBER, nums[i], 4'(i), $urandom);
		// raw mode, with the unused number fields at their extremes
		for (int i = 0; i < 5; i++)
			send_item(ssbs_pkg::CMD_RAW, (i % 2) ? 16'hFFFF : 16'h0000,
				(i % 2) ? 4'hF : 4'h0, raws[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pace_sender();
			c = ($urandom_range(0, 9) < 6) ? ssbs_pkg::CMD_NUMBER : ssbs_pkg::CMD_RAW;
			send_item(c, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 999))
				: 16'($urandom), 4'($urandom), $urandom);
		end
		item_valid = 1'b0;

		while (pending_bits != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (mismatch_count == 0 && pending_bits == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
